FILE: hw/rtl/agstep_pkg.sv
// Shared types and constants of the adaptive gradient step block.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package agstep_pkg;

   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 16;
   localparam int VALUE_W    = 32;
   localparam int CLASS_W    = 2;
   localparam int MODE_W     = 2;
   localparam int FACTOR_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // input commands
   localparam logic [CMD_W-1:0] CMD_GRAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // optimizer modes
   localparam logic [MODE_W-1:0] MODE_PLAIN   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADAGRAD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RMSPROP = 2'd2;
   localparam logic [MODE_W-1:0] MODE_ADAM    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_RATE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_RATE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_RATE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRN_RATE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FAC = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_PER = 3'd6;

   localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_ADAM;
   localparam logic [VALUE_W-1:0]  RATE_RESET   = 32'd6554;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd49152;
   localparam logic [FACTOR_W-1:0] PERIOD_RESET = 16'd100;

   localparam logic [47:0] SAT_POS_MAG = 48'h0000_7FFF_FFFF;
   localparam logic [47:0] SAT_NEG_MAG = 48'h0000_8000_0000;
   localparam logic [47:0] STORE_MAX   = 48'h0000_7FFF_FFFF;

   typedef enum logic [1:0] {
      OP_GRAD,
      OP_TICK,
      OP_START
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [INDEX_W-1:0]         index;
      logic signed [VALUE_W-1:0]  gradient;
      logic [CLASS_W-1:0]         rate_class;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_out_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [3:0][VALUE_W-1:0]   rates;
      logic [FACTOR_W-1:0]       factor;
      logic [FACTOR_W-1:0]       period;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REM,
      ST_READ,
      ST_UPDATE,
      ST_SQRT,
      ST_DIV,
      ST_CLAMP,
      ST_SCALE,
      ST_SAT,
      ST_DECAY
   } back_state_type;

endpackage

FILE: hw/rtl/agstep_if.sv
// Channel interfaces of the adaptive gradient step block: request, response, csr write.
// Depends on agstep_pkg.
`timescale 1ns / 1ps

interface agstep_req_if import agstep_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic [INDEX_W-1:0]        element_index;
   logic signed [VALUE_W-1:0] gradient;
   logic [CLASS_W-1:0]        rate_class;

   modport source (output valid, command, element_index, gradient, rate_class, input ready);
   modport sink (input valid, command, element_index, gradient, rate_class, output ready);
endinterface

interface agstep_rsp_if import agstep_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [INDEX_W-1:0]        step_index;
   logic signed [VALUE_W-1:0] step_value;

   modport source (output valid, step_index, step_value, input ready);
   modport sink (input valid, step_index, step_value, output ready);
endinterface

interface agstep_csr_if import agstep_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/agstep_csr.sv
// Configuration registers of the adaptive gradient step block.
// Depends on agstep_pkg and agstep_csr_if.
`timescale 1ns / 1ps

module agstep_csr import agstep_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   agstep_csr_if.sink   csr,
   output cfg_type      cfg
);

   cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= MODE_RESET;
         cfg_ff.rates  <= {4{RATE_RESET}};
         cfg_ff.factor <= FACTOR_RESET;
         cfg_ff.period <= PERIOD_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_MODE:      cfg_ff.mode     <= csr.data[MODE_W-1:0];
            CSR_POS_RATE:  cfg_ff.rates[0] <= csr.data;
            CSR_COL_RATE:  cfg_ff.rates[1] <= csr.data;
            CSR_TEX_RATE:  cfg_ff.rates[2] <= csr.data;
            CSR_TRN_RATE:  cfg_ff.rates[3] <= csr.data;
            CSR_DECAY_FAC: cfg_ff.factor   <= csr.data[FACTOR_W-1:0];
            CSR_DECAY_PER: cfg_ff.period   <= csr.data[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

FILE: hw/rtl/agstep_front.sv
// Front end: accepts request transfers, classifies the command and queues the item.
// Depends on agstep_pkg and agstep_req_if.
`timescale 1ns / 1ps

module agstep_front import agstep_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   agstep_req_if.sink    req,
   input  logic          pop,
   output queue_out_type head
);

   entry_type  slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       accept, push;
   entry_type  entry;

   assign req.ready = (fill_ff != 2'd2);
   assign accept    = req.valid && req.ready;

   // drop the unused command at the door
   always_comb begin
      entry.index      = req.element_index;
      entry.gradient   = req.gradient;
      entry.rate_class = req.rate_class;
      entry.op         = OP_GRAD;
      push             = accept;
      unique case (req.command)
         CMD_GRAD:  entry.op = OP_GRAD;
         CMD_TICK:  entry.op = OP_TICK;
         CMD_START: entry.op = OP_START;
         default:   push     = 1'b0;
      endcase
   end

   assign wptr_in = push ? ~wptr_ff : wptr_ff;
   assign rptr_in = pop ? ~rptr_ff : rptr_ff;
   assign fill_in = 2'(fill_ff + {1'b0, push} - {1'b0, pop});

   assign head.valid = (fill_ff != 2'd0);
   assign head.entry = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= entry;
   end

endmodule

FILE: hw/rtl/agstep_back.sv
// Back end: sequencer, element stores, shared multiplier, serial remainder,
// square root and divide units, class rates and the response register.
// Depends on agstep_pkg and agstep_rsp_if.
`timescale 1ns / 1ps

module agstep_back import agstep_pkg::*; #(
   parameter int ELEMENT_DEPTH = 65536
) (
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type head,
   output logic          pop,
   input  cfg_type       cfg,
   agstep_rsp_if.source  rsp
);

   localparam int AW = $clog2(ELEMENT_DEPTH);
   localparam int RW = FACTOR_W + 1;
   // reciprocal of the depth, exact for every 16-bit index
   localparam logic [31:0] RECIP   = 32'(((64'd1 << 32) + 64'(ELEMENT_DEPTH) - 64'd1)
                                         / 64'(ELEMENT_DEPTH));
   localparam logic [31:0] DEPTH_W = 32'(ELEMENT_DEPTH);

   back_state_type state_ff, state_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic [AW-1:0]           clr_ff, clr_in;
   entry_type               entry_ff, entry_in;
   logic [RW-1:0]           rem_ff, rem_in;
   logic [RW-1:0]           divisor_ff, divisor_in;
   logic [31:0]             divd_ff, divd_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [63:0]             prod_ff, prod_in;
   logic                    neg_ff, neg_in;
   logic [31:0]             mag_ff, mag_in;
   logic [47:0]             rad_ff, rad_in;
   logic [25:0]             srem_ff, srem_in;
   logic [23:0]             root_ff, root_in;
   logic [47:0]             num_ff, num_in;
   logic [23:0]             drem_ff, drem_in;
   logic [3:0][31:0]        rates_ff, rates_in;
   logic [31:0]             count_ff, count_in;
   logic                    outv_ff, outv_in;
   logic [INDEX_W-1:0]      outidx_ff, outidx_in;
   logic [VALUE_W-1:0]      outval_ff, outval_in;

   logic [31:0] sq_mem [ELEMENT_DEPTH];
   logic [31:0] mo_mem [ELEMENT_DEPTH];
   logic [31:0] sq_rd_ff, mo_rd_ff;
   logic        sq_we, mo_we;
   logic [AW-1:0] wr_addr;
   logic [31:0] sq_wd, mo_wd;

   // shared datapath terms
   logic [RW-1:0] rem_t, rem_step;
   logic [27:0]   sq_t, sq_trial;
   logic [24:0]   dv_t;
   logic          dv_bit;
   logic [31:0]   gm;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p;
   logic          clr_last, decay_now, out_free;
   logic [47:0]   limit;

   assign rem_t    = {rem_ff[RW-2:0], divd_ff[31]};
   assign rem_step = (rem_t >= divisor_ff) ? rem_t - divisor_ff : rem_t;
   assign sq_t     = {srem_ff, rad_ff[47:46]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign dv_t     = {drem_ff, num_ff[47]};
   assign dv_bit   = (dv_t >= {1'b0, root_ff});
   assign gm       = entry_ff.gradient[31] ? ~entry_ff.gradient + 32'd1 : entry_ff.gradient;
   assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
   assign clr_last = (clr_ff == AW'(ELEMENT_DEPTH - 1));
   assign decay_now = (count_ff != 32'd0) && (rem_step == '0);
   assign out_free = !outv_ff || rsp.ready;
   assign limit    = neg_ff ? SAT_NEG_MAG : SAT_POS_MAG;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (head.valid) begin
               unique case (head.entry.op)
                  OP_START: state_in = ST_CLEAR;
                  OP_TICK:  state_in = (cfg.period == '0) ? ST_IDLE : ST_REM;
                  default:  state_in = ST_REM;
               endcase
            end
         end
         ST_REM: begin
            if (entry_ff.op != OP_TICK) begin
               state_in = (cfg.mode == MODE_PLAIN) ? ST_SCALE : ST_READ;
            end else if (cnt_ff == 6'd31) begin
               state_in = decay_now ? ST_DECAY : ST_IDLE;
            end
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SQRT;
         ST_SQRT:   if (cnt_ff == 6'd23) state_in = ST_DIV;
         ST_DIV:    if (cnt_ff == 6'd47) state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_SAT;
         ST_SAT:    if (out_free) state_in = ST_IDLE;
         ST_DECAY:  if (cnt_ff == 6'd3) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [47:0] ssum;
      logic [31:0] s_sat;
      logic [33:0] g3;
      logic [34:0] msum;
      logic [31:0] m;
      logic [31:0] val;
      logic [47:0] p;
      logic [31:0] smag;

      cnt_in     = (state_in != state_ff) ? 6'd0 : 6'(cnt_ff + 6'd1);
      clr_in     = clr_ff;
      entry_in   = entry_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      divd_in    = divd_ff;
      addr_in    = addr_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      rad_in     = rad_ff;
      srem_in    = srem_ff;
      root_in    = root_ff;
      num_in     = num_ff;
      drem_in    = drem_ff;
      rates_in   = rates_ff;
      count_in   = count_ff;
      outidx_in  = outidx_ff;
      outval_in  = outval_ff;
      outv_in    = outv_ff && !rsp.ready;
      pop        = 1'b0;
      sq_we      = 1'b0;
      mo_we      = 1'b0;
      sq_wd      = 32'd0;
      mo_wd      = 32'd0;
      wr_addr    = addr_ff;
      mul_a      = gm;
      mul_b      = gm;

      ssum  = {16'd0, sq_rd_ff} + prod_ff[63:16];
      s_sat = (ssum > STORE_MAX) ? STORE_MAX[31:0] : ssum[31:0];
      g3    = {{2{entry_ff.gradient[31]}}, entry_ff.gradient}
            + {entry_ff.gradient[31], entry_ff.gradient, 1'b0};
      msum  = {{3{mo_rd_ff[31]}}, mo_rd_ff} + {g3[33], g3};
      m     = msum[33:2];
      val   = (cfg.mode == MODE_ADAM) ? m : entry_ff.gradient;
      p     = prod_ff[63:16];
      smag  = (p > limit) ? limit[31:0] : p[31:0];

      unique case (state_ff)
         ST_CLEAR: begin
            wr_addr = clr_ff;
            sq_we   = 1'b1;
            mo_we   = 1'b1;
            clr_in  = AW'(clr_ff + 1'b1);
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               entry_in = head.entry;
               rem_in   = '0;
               unique case (head.entry.op)
                  OP_START: begin
                     clr_in   = '0;
                     count_in = 32'd0;
                     rates_in = cfg.rates;
                  end
                  OP_TICK: begin
                     divd_in    = count_ff;
                     divisor_in = RW'(cfg.period);
                     if (cfg.period == '0) count_in = count_ff + 32'd1;
                  end
                  default: begin
                     // quotient of the index by the depth
                     mul_a   = {16'd0, head.entry.index};
                     mul_b   = RECIP;
                     divd_in = mul_p[63:32];
                  end
               endcase
            end
         end
         ST_REM: begin
            if (entry_ff.op == OP_TICK) begin
               rem_in  = rem_step;
               divd_in = {divd_ff[30:0], 1'b0};
               if (cnt_ff == 6'd31 && !decay_now) count_in = count_ff + 32'd1;
            end else begin
               addr_in = AW'({16'd0, entry_ff.index} - 32'(divd_ff[15:0]) * DEPTH_W);
               neg_in  = entry_ff.gradient[31];
               mag_in  = gm;
            end
         end
         ST_READ: prod_in = mul_p;
         ST_UPDATE: begin
            sq_we   = 1'b1;
            sq_wd   = s_sat;
            mo_we   = (cfg.mode == MODE_ADAM);
            mo_wd   = m;
            neg_in  = val[31];
            mag_in  = val[31] ? ~val + 32'd1 : val;
            rad_in  = {s_sat + 32'd1, 16'd0};
            srem_in = '0;
            root_in = '0;
         end
         ST_SQRT: begin
            rad_in = {rad_ff[45:0], 2'b00};
            if (sq_t >= sq_trial) begin
               srem_in = 26'(sq_t - sq_trial);
               root_in = {root_ff[22:0], 1'b1};
            end else begin
               srem_in = sq_t[25:0];
               root_in = {root_ff[22:0], 1'b0};
            end
            if (cnt_ff == 6'd23) begin
               num_in  = {mag_ff, 16'd0};
               drem_in = '0;
            end
         end
         ST_DIV: begin
            drem_in = dv_bit ? 24'(dv_t - {1'b0, root_ff}) : dv_t[23:0];
            num_in  = {num_ff[46:0], dv_bit};
         end
         ST_CLAMP: mag_in = (num_ff > limit) ? limit[31:0] : num_ff[31:0];
         ST_SCALE: begin
            mul_a   = mag_ff;
            mul_b   = rates_ff[entry_ff.rate_class];
            prod_in = mul_p;
         end
         ST_SAT: begin
            if (out_free) begin
               outv_in   = 1'b1;
               outidx_in = entry_ff.index;
               outval_in = neg_ff ? ~smag + 32'd1 : smag;
            end
         end
         ST_DECAY: begin
            mul_a = rates_ff[cnt_ff[1:0]];
            mul_b = {16'd0, cfg.factor};
            rates_in[cnt_ff[1:0]] = mul_p[47:16];
            if (cnt_ff == 6'd3) count_in = count_ff + 32'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= 6'd0;
         clr_ff   <= '0;
         rates_ff <= {4{RATE_RESET}};
         count_ff <= 32'd0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         clr_ff   <= clr_in;
         rates_ff <= rates_in;
         count_ff <= count_in;
         outv_ff  <= outv_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff   <= entry_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      divd_ff    <= divd_in;
      addr_ff    <= addr_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      rad_ff     <= rad_in;
      srem_ff    <= srem_in;
      root_ff    <= root_in;
      num_ff     <= num_in;
      drem_ff    <= drem_in;
      outidx_ff  <= outidx_in;
      outval_ff  <= outval_in;
   end

   // element stores
   always_ff @(posedge clock) begin
      if (sq_we) sq_mem[wr_addr] <= sq_wd;
      if (mo_we) mo_mem[wr_addr] <= mo_wd;
      sq_rd_ff <= sq_mem[addr_ff];
      mo_rd_ff <= mo_mem[addr_ff];
   end

   assign rsp.valid      = outv_ff;
   assign rsp.step_index = outidx_ff;
   assign rsp.step_value = outval_ff;

endmodule

FILE: hw/rtl/adaptive_gradient_step.sv
// Top level of the adaptive gradient step block: csr registers, front queue, back sequencer.
// Depends on agstep_pkg, the agstep interfaces, agstep_csr, agstep_front and agstep_back.
//
//   channel    dir  transfer when        payload
//   req_chan   in   valid && ready       command, element_index, gradient, rate_class
//   rsp_chan   out  valid && ready       step_index, step_value
//   csr_chan   in   valid && ready       index, data (ready is always high)
//
// Items go one at a time through the back sequencer; a two-entry queue and the
// response register let each side stall on its own. A gradient element in plain mode
// goes straight to scaling; in the adaptive modes it first passes the 24-step square
// root and 48-step divide; in either mode a response stall can hold it. A tick with a
// zero period only counts; else it runs the serial remainder, then decays the four rates
// when they are due. Start and reset run a clearing pass over all ELEMENT_DEPTH entries.
`timescale 1ns / 1ps

module adaptive_gradient_step import agstep_pkg::*; #(
   parameter int ELEMENT_DEPTH = 65536
) (
   input  logic         clock,
   input  logic         reset,
   agstep_req_if.sink   req_chan,
   agstep_rsp_if.source rsp_chan,
   agstep_csr_if.sink   csr_chan
);

   cfg_type       cfg;
   queue_out_type head;
   logic          pop;

   agstep_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   agstep_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .pop   (pop),
      .head  (head)
   );

   agstep_back #(
      .ELEMENT_DEPTH (ELEMENT_DEPTH)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .cfg   (cfg),
      .rsp   (rsp_chan)
   );

endmodule
